@@ hw/rtl/mwdbh_pkg.sv @@
`default_nettype none

package mwdbh_pkg;

   // Machine types selected by the first configuration register.
   typedef enum logic [2:0] {
      MACH_PLAIN  = 3'd0,
      MACH_SGM    = 3'd1,
      MACH_SG1000 = 3'd2,
      MACH_SORDM5 = 3'd3,
      MACH_MSX    = 3'd4
   } machine_type_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_MACHINE_TYPE  = 3'd0,
      CSR_SGM_LOW       = 3'd1,
      CSR_RAM_FLOOR     = 3'd2,
      CSR_RAM_CEILING   = 3'd3,
      CSR_SRAM_E000     = 3'd4,
      CSR_BANKED_ENABLE = 3'd5,
      CSR_ALT_ENABLE    = 3'd6,
      CSR_BANK_MASK     = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Access kind of an input item.
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Address map constants.
   localparam logic [15:0] ADDR_UPPER_RAM   = 16'h8000;
   localparam logic [15:0] ADDR_LOW_WIN_LO  = 16'h2000;
   localparam logic [15:0] ADDR_LOW_WIN_HI  = 16'h4000;
   localparam logic [15:0] ADDR_M5_RAM      = 16'h7000;
   localparam logic [15:0] ADDR_MIRROR_LO   = 16'h6000;
   localparam logic [15:0] ADDR_BELOW_MIRR  = 16'h5FFF;
   localparam logic [15:0] MIRROR_MASK      = 16'h03FF;
   localparam logic [15:0] ADDR_SRAM_LO     = 16'hE000;
   localparam logic [15:0] ADDR_SRAM_HI     = 16'hE800;
   localparam logic [15:0] SRAM_OFFSET      = 16'h0800;
   localparam logic [15:0] ADDR_HOTSPOT     = 16'hFFC0;
   localparam logic [15:0] ADDR_ALT_HOT0    = 16'hFF90;
   localparam logic [15:0] ADDR_ALT_HOT1    = 16'hFFA0;
   localparam logic [15:0] ADDR_ALT_HOT2    = 16'hFFB0;
   localparam logic [7:0]  NO_BANK_YET      = 8'd199;

   // Configuration reset values.
   localparam logic [15:0] SGM_LOW_RESET     = 16'h2000;
   localparam logic [15:0] RAM_FLOOR_RESET   = 16'hC000;
   localparam logic [15:0] RAM_CEILING_RESET = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  machine_type;
      logic [15:0] sgm_low_address;
      logic [15:0] ram_floor;
      logic [15:0] ram_ceiling;
      logic        sram_e000_enable;
      logic        banked_enable;
      logic        alt_hotspot_enable;
      logic [7:0]  bank_mask;
   } cfg_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] address;
      logic [7:0]  write_data;
   } access_type;

   typedef struct packed {
      logic        store_enable;
      logic [15:0] store_address;
      logic [7:0]  store_data;
      logic        mirror_all;
      logic        bank_switch;
      logic [7:0]  new_bank;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/mwdbh_csr.sv @@
`default_nettype none

module mwdbh_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [mwdbh_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   output mwdbh_pkg::cfg_type                        cfg
);

   mwdbh_pkg::cfg_type cfg_ff;
   mwdbh_pkg::cfg_type cfg_in;

   // Register write decode; each register keeps only its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (mwdbh_pkg::csr_index_type'(csr_index))
            mwdbh_pkg::CSR_MACHINE_TYPE:  cfg_in.machine_type       = csr_data[2:0];
            mwdbh_pkg::CSR_SGM_LOW:       cfg_in.sgm_low_address    = csr_data[15:0];
            mwdbh_pkg::CSR_RAM_FLOOR:     cfg_in.ram_floor          = csr_data[15:0];
            mwdbh_pkg::CSR_RAM_CEILING:   cfg_in.ram_ceiling        = csr_data[15:0];
            mwdbh_pkg::CSR_SRAM_E000:     cfg_in.sram_e000_enable   = csr_data[0];
            mwdbh_pkg::CSR_BANKED_ENABLE: cfg_in.banked_enable      = csr_data[0];
            mwdbh_pkg::CSR_ALT_ENABLE:    cfg_in.alt_hotspot_enable = csr_data[0];
            mwdbh_pkg::CSR_BANK_MASK:     cfg_in.bank_mask          = csr_data[7:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.machine_type       <= mwdbh_pkg::MACH_PLAIN;
         cfg_ff.sgm_low_address    <= mwdbh_pkg::SGM_LOW_RESET;
         cfg_ff.ram_floor          <= mwdbh_pkg::RAM_FLOOR_RESET;
         cfg_ff.ram_ceiling        <= mwdbh_pkg::RAM_CEILING_RESET;
         cfg_ff.sram_e000_enable   <= 1'b0;
         cfg_ff.banked_enable      <= 1'b0;
         cfg_ff.alt_hotspot_enable <= 1'b0;
         cfg_ff.bank_mask          <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mwdbh_decode.sv @@
`default_nettype none

module mwdbh_decode (
   input  wire logic           clock,
   input  wire logic           reset,
   input  mwdbh_pkg::cfg_type    cfg,
   input  mwdbh_pkg::access_type access,
   input  wire logic           advance,
   output mwdbh_pkg::result_type result,
   output logic [7:0]          current_bank
);

   logic [7:0] bank_ff;
   logic [7:0] bank_in;
   logic       store;
   logic [15:0] store_addr;
   logic       mirror;
   logic       request;
   logic [7:0] request_bank;
   logic [15:0] a;
   logic       hot_high;
   logic       alt_hit;

   assign a        = access.address;
   assign hot_high = (a >= mwdbh_pkg::ADDR_HOTSPOT);
   assign alt_hit  = (a == mwdbh_pkg::ADDR_ALT_HOT0) || (a == mwdbh_pkg::ADDR_ALT_HOT1) ||
                     (a == mwdbh_pkg::ADDR_ALT_HOT2);

   // Write address window decode by machine type (unused types decode as plain); reads decode only the bank hotspot.
   always_comb begin
      store        = 1'b0;
      store_addr   = 16'd0;
      mirror       = 1'b0;
      request      = 1'b0;
      request_bank = 8'd0;
      if (access.mode == mwdbh_pkg::MODE_READ) begin
         if (cfg.banked_enable && (cfg.bank_mask != 8'd0) && hot_high) begin
            request      = 1'b1;
            request_bank = a[7:0] & cfg.bank_mask;
         end
      end else begin
         unique case (cfg.machine_type)
            mwdbh_pkg::MACH_SG1000: begin
               store = (a >= mwdbh_pkg::ADDR_UPPER_RAM) ||
                       ((a >= mwdbh_pkg::ADDR_LOW_WIN_LO) && (a < mwdbh_pkg::ADDR_LOW_WIN_HI));
               store_addr = a;
            end
            mwdbh_pkg::MACH_SORDM5: begin
               store      = (a >= mwdbh_pkg::ADDR_M5_RAM);
               store_addr = a;
            end
            mwdbh_pkg::MACH_MSX: begin
               store      = (a >= cfg.ram_floor) && (a <= cfg.ram_ceiling);
               store_addr = a;
            end
            mwdbh_pkg::MACH_SGM: begin
               store      = (a >= cfg.sgm_low_address) && (a < mwdbh_pkg::ADDR_UPPER_RAM);
               store_addr = a;
            end
            default: begin
               if ((a > mwdbh_pkg::ADDR_BELOW_MIRR) && (a < mwdbh_pkg::ADDR_UPPER_RAM)) begin
                  store      = 1'b1;
                  store_addr = mwdbh_pkg::ADDR_MIRROR_LO + (a & mwdbh_pkg::MIRROR_MASK);
                  mirror     = 1'b1;
               end else if ((a >= mwdbh_pkg::ADDR_SRAM_LO) && (a < mwdbh_pkg::ADDR_SRAM_HI)) begin
                  store      = cfg.sram_e000_enable;
                  store_addr = a + mwdbh_pkg::SRAM_OFFSET;
               end else if (hot_high) begin
                  request      = cfg.banked_enable;
                  request_bank = a[7:0] & cfg.bank_mask;
               end else if (cfg.alt_hotspot_enable && alt_hit) begin
                  request      = 1'b1;
                  request_bank = a[11:4] & cfg.bank_mask;
               end
            end
         endcase
      end
   end

   // Result assembly; a switch only when the bank differs from the mapped one.
   always_comb begin
      result.store_enable  = store;
      result.store_address = store ? store_addr : 16'd0;
      result.store_data    = store ? access.write_data : 8'd0;
      result.mirror_all    = store & mirror;
      result.bank_switch   = request && (request_bank != bank_ff);
      result.new_bank      = result.bank_switch ? request_bank : 8'd0;
      bank_in              = (advance && result.bank_switch) ? request_bank : bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= mwdbh_pkg::NO_BANK_YET;
      end else begin
         bank_ff <= bank_in;
      end
   end

   assign current_bank = bank_ff;

endmodule

`default_nettype wire

@@ hw/rtl/memory_write_decoder_bank_hotspot.sv @@
// Path: an accepted item waits in the input register, is decoded, and is registered in the result register.
// Throughput: one item per cycle while rsp_stall is low; decode is one pass between input and result registers.
// The request side stalls only when the result register is full and stalled.
// Synchronous reset clears both valid flags, loads configuration reset values
// and sets the mapped bank to 199 (no bank yet).
`default_nettype none

module memory_write_decoder_bank_hotspot (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_mode,
   input  wire logic [15:0]                          req_address,
   input  wire logic [7:0]                           req_write_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_store_enable,
   output logic [15:0]                               rsp_store_address,
   output logic [7:0]                                rsp_store_data,
   output logic                                      rsp_mirror_all,
   output logic                                      rsp_bank_switch,
   output logic [7:0]                                rsp_new_bank,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [mwdbh_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   mwdbh_pkg::cfg_type    cfg;
   mwdbh_pkg::access_type access_ff;
   mwdbh_pkg::access_type access_in;
   mwdbh_pkg::result_type result;
   mwdbh_pkg::result_type result_ff;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  advance;
   logic                  req_take;
   logic [7:0]            current_bank;

   assign csr_ready = 1'b1;

   mwdbh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake: the decode stage moves when the result register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      access_in.mode       = req_mode;
      access_in.address    = req_address;
      access_in.write_data = req_write_data;
      in_valid_in          = req_take || (in_valid_ff && !advance);
      out_valid_in         = advance || (out_valid_ff && rsp_stall);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         access_ff <= access_in;
      end
   end

   mwdbh_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .access       (access_ff),
      .advance      (advance),
      .result       (result),
      .current_bank (current_bank)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_store_enable  = result_ff.store_enable;
   assign rsp_store_address = result_ff.store_address;
   assign rsp_store_data    = result_ff.store_data;
   assign rsp_mirror_all    = result_ff.mirror_all;
   assign rsp_bank_switch   = result_ff.bank_switch;
   assign rsp_new_bank      = result_ff.new_bank;

   // A delivered switch names the bank now recorded as mapped.
   a_switch_tracks_bank: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.bank_switch) |-> (current_bank == result_ff.new_bank))
      else $error("switched bank differs from mapped bank");

   // Mirrored stores stay in the 1K block at 6000.
   a_mirror_block: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.mirror_all) |->
      (result_ff.store_enable && (result_ff.store_address[15:10] == 6'b011000)))
      else $error("mirrored store outside the base block");

   // Without a store the address and data fields are zero.
   a_no_store_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !result_ff.store_enable) |->
      ((result_ff.store_address == 16'd0) && (result_ff.store_data == 8'd0)))
      else $error("store fields set without a store");

   // The mapped bank changes only when a switching item moves to the result register.
   a_bank_change: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(current_bank))
      else $error("mapped bank changed without an item");

endmodule

`default_nettype wire
